[hw/rtl/oed_pkg.sv]
// Shared types and constants of the octal escape decoder.
`timescale 1ns / 1ps
package oed_pkg;

  localparam int unsigned LengthBits = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [1:0] MaxDigits = 2'd3;
  localparam logic [LengthBits-1:0] CapacityReset = LengthBits'(256);
  localparam logic [LengthBits-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    ModeNormal,
    ModeEscape,
    ModeDigits
  } mode_e;

  // One classified item: up to two data bytes and an optional summary.
  typedef struct packed {
    logic                  a_v;
    logic [7:0]            a;
    logic                  b_v;
    logic [7:0]            b;
    logic                  s_v;
    logic [LengthBits-1:0] len;
    logic                  st;
  } entry_t;

endpackage

[hw/rtl/oed_front.sv]
// Front part: accepts source characters, tracks escape state, classifies results.
`timescale 1ns / 1ps
module oed_front import oed_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            in_char_i,
  input  logic                  last_char_i,
  input  logic                  cfg_we_i,
  input  logic [LengthBits-1:0] cfg_data_i,
  output logic                  q_push_o,
  output entry_t                q_entry_o
);

  logic [LengthBits-1:0] cap_q;
  mode_e                 mode_q, mode_d;
  logic [1:0]            dig_q, dig_d;
  logic [7:0]            oct_q, oct_d;
  logic [LengthBits-1:0] cnt_q, cnt_d;
  logic                  stop_q, stop_d;
  logic                  halt_q, halt_d;

  logic                  is_oct;
  logic [2:0]            digit;
  logic                  e1;
  logic [7:0]            e1_byte;
  logic                  do_normal;
  logic [LengthBits-1:0] len;
  entry_t                ent;

  assign is_oct = (in_char_i >= ChZero) && (in_char_i <= ChSeven);
  assign digit  = in_char_i[2:0];

  // Work out the state update and the results of one character.
  always_comb begin
    mode_d    = mode_q;
    dig_d     = dig_q;
    oct_d     = oct_q;
    cnt_d     = cnt_q;
    stop_d    = stop_q;
    halt_d    = halt_q;
    e1        = 1'b0;
    e1_byte   = 8'h00;
    do_normal = 1'b0;
    len       = '0;
    ent       = '0;

    if (!halt_q) begin
      case (mode_q)
        ModeNormal: begin
          do_normal = 1'b1;
        end
        ModeEscape: begin
          if (in_char_i == ChBackslash) begin
            mode_d  = ModeNormal;
            e1      = 1'b1;
            e1_byte = ChBackslash;
          end else if (is_oct) begin
            oct_d  = {5'd0, digit};
            dig_d  = 2'd1;
            mode_d = ModeDigits;
            if (last_char_i) begin
              mode_d  = ModeNormal;
              e1      = 1'b1;
              e1_byte = {5'd0, digit};
            end
          end else begin
            mode_d    = ModeNormal;
            e1        = 1'b1;
            e1_byte   = 8'h00;
            do_normal = 1'b1;
          end
        end
        ModeDigits: begin
          if (is_oct && (dig_q < MaxDigits)) begin
            oct_d = {oct_q[4:0], digit};
            dig_d = dig_q + 2'd1;
            if ((dig_d >= MaxDigits) || last_char_i) begin
              mode_d  = ModeNormal;
              e1      = 1'b1;
              e1_byte = oct_d;
            end
          end else begin
            mode_d    = ModeNormal;
            e1        = 1'b1;
            e1_byte   = oct_q;
            do_normal = 1'b1;
          end
        end
        default: begin
          mode_d = ModeNormal;
        end
      endcase
    end

    // First byte of the escape; the terminator slot swallows it when full.
    if (e1) begin
      ent.a_v = (({1'b0, cnt_d} + (LengthBits + 1)'(1)) < {1'b0, cap_q});
      ent.a   = e1_byte;
      if (cnt_d != CountMax) begin
        cnt_d = cnt_d + 1'b1;
      end
    end

    // The character itself, handled as ordinary text.
    if (do_normal) begin
      if ((cnt_d == cap_q) || (in_char_i == 8'h00)) begin
        halt_d = 1'b1;
        stop_d = 1'b1;
      end else if (in_char_i == ChBackslash) begin
        mode_d = ModeEscape;
      end else begin
        ent.b_v = (({1'b0, cnt_d} + (LengthBits + 1)'(1)) < {1'b0, cap_q});
        ent.b   = in_char_i;
        if (cnt_d != CountMax) begin
          cnt_d = cnt_d + 1'b1;
        end
      end
    end

    // Summary on the last character, then back to the cleared state.
    if (last_char_i) begin
      len = cnt_d;
      if ((len != '0) && (len == cap_q)) begin
        len = len - 1'b1;
      end
      ent.s_v = 1'b1;
      ent.len = len;
      ent.st  = stop_d;
      mode_d  = ModeNormal;
      dig_d   = '0;
      oct_d   = '0;
      cnt_d   = '0;
      stop_d  = 1'b0;
      halt_d  = 1'b0;
    end
  end

  assign q_push_o  = accept_i && (ent.a_v || ent.b_v || ent.s_v);
  assign q_entry_o = ent;

  // Decoder state and capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapacityReset;
      mode_q <= ModeNormal;
      dig_q  <= '0;
      oct_q  <= '0;
      cnt_q  <= '0;
      stop_q <= 1'b0;
      halt_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (accept_i) begin
        mode_q <= mode_d;
        dig_q  <= dig_d;
        oct_q  <= oct_d;
        cnt_q  <= cnt_d;
        stop_q <= stop_d;
        halt_q <= halt_d;
      end
    end
  end

endmodule

[hw/rtl/oed_queue.sv]
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps
module oed_queue import oed_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  output logic   valid_o,
  output entry_t entry_o,
  input  logic   pop_i
);

  entry_t                  mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrBits:0]   count_q;
  logic                    do_push, do_pop;

  assign full_o  = (count_q == (QueuePtrBits + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/oed_back.sv]
// Back part: splits each classified item into result items behind an output register.
`timescale 1ns / 1ps
module oed_back import oed_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  entry_t                q_entry_i,
  output logic                  q_pop_o,
  output logic                  empty,
  input  logic                  pop,
  output logic                  kind_o,
  output logic [7:0]            out_byte_o,
  output logic [LengthBits-1:0] length_o,
  output logic                  status_o,
  output logic                  run_end_o
);

  logic [2:0]            done_q, done_d;
  logic                  out_v_q, out_v_d;
  logic                  kind_q, kind_d;
  logic [7:0]            byte_q, byte_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic                  st_q, st_d;
  logic                  end_q, end_d;
  logic [2:0]            rem, sel;
  logic                  load;

  assign rem  = {q_entry_i.s_v, q_entry_i.b_v, q_entry_i.a_v} & ~done_q;
  assign load = q_valid_i && (!out_v_q || pop);

  // Pick the oldest outstanding result of the head item.
  always_comb begin
    sel    = 3'b000;
    kind_d = kind_q;
    byte_d = byte_q;
    len_d  = len_q;
    st_d   = st_q;
    end_d  = end_q;
    done_d = done_q;
    q_pop_o = 1'b0;
    out_v_d = out_v_q && !pop;

    if (rem[0]) begin
      sel = 3'b001;
    end else if (rem[1]) begin
      sel = 3'b010;
    end else begin
      sel = 3'b100;
    end

    if (load) begin
      out_v_d = 1'b1;
      kind_d  = sel[2];
      byte_d  = sel[0] ? q_entry_i.a : (sel[1] ? q_entry_i.b : 8'h00);
      len_d   = sel[2] ? q_entry_i.len : '0;
      st_d    = sel[2] && q_entry_i.st;
      end_d   = ((rem & ~sel) == 3'b000);
      if (end_d) begin
        done_d  = 3'b000;
        q_pop_o = 1'b1;
      end else begin
        done_d = done_q | sel;
      end
    end
  end

  // Output register and progress through the head item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      done_q  <= 3'b000;
    end else begin
      out_v_q <= out_v_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    len_q  <= len_d;
    st_q   <= st_d;
    end_q  <= end_d;
  end

  assign empty      = !out_v_q;
  assign kind_o     = kind_q;
  assign out_byte_o = byte_q;
  assign length_o   = len_q;
  assign status_o   = st_q;
  assign run_end_o  = end_q;

endmodule

[hw/rtl/octal_escape_decoder_top.sv]
// Top level of the octal escape decoder.
`timescale 1ns / 1ps
// Usage:
// Source characters enter on a queue-style port: an item is taken at a clock
// edge with push high and full low. Results leave the same way: the oldest
// result sits on the result ports while empty is low and is taken at an edge
// with pop high. Each character gives none to three results; the last one of
// a character carries run_end, and a character marked last always ends with a
// summary item holding the decoded length and the stop status.
// One character is taken every cycle while full is low. When the output
// register is free, the first result of a character appears on the ports at
// the edge after the one that takes the character; further results of it
// follow one per cycle while pop is high. The back part hands out one result
// per cycle, so characters that give two or three results are absorbed by a
// four-item queue between front and back, and push stalls only when that
// queue fills. When pop is held low the output register and queue hold their
// contents and full rises once the queue is full; nothing is lost.
// The capacity register is written through its own valid/ready channel,
// which is always ready, and should be written only while the block is idle.
// Reset clears all decoder state, empties the queue and sets capacity to 256.
module octal_escape_decoder_top import oed_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_char_i,
  input  logic                  last_char_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  kind_o,
  output logic [7:0]            out_byte_o,
  output logic [LengthBits-1:0] length_o,
  output logic                  status_o,
  output logic                  run_end_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [LengthBits-1:0] out_capacity_i
);

  logic   accept;
  logic   q_push, q_valid, q_pop;
  entry_t q_in, q_out;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // Front: escape state machine and classification.
  oed_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_char_i   (in_char_i),
    .last_char_i (last_char_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (out_capacity_i),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  // Queue between the two parts.
  oed_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (q_out),
    .pop_i   (q_pop)
  );

  // Back: serialises results onto the output port.
  oed_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_out),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .kind_o     (kind_o),
    .out_byte_o (out_byte_o),
    .length_o   (length_o),
    .status_o   (status_o),
    .run_end_o  (run_end_o)
  );

  // A summary is always the final result of its character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o) |-> run_end_o)
    else $error("summary item without run_end");

  // Data items carry neither length nor status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !kind_o) |-> (length_o == '0 && !status_o))
    else $error("data item with summary fields set");

  // Summary items carry a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o) |-> (out_byte_o == 8'h00))
    else $error("summary item with nonzero byte");

  // A result held back by the receiver stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(kind_o)))
    else $error("stalled result changed");

endmodule

[tb/octal_escape_decoder_checker.sv]
// Checker of the octal escape decoder: predicts every result and compares it.
`timescale 1ns / 1ps
module octal_escape_decoder_checker import oed_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  logic [7:0]            in_char_i,
  input  logic                  last_char_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  logic                  kind_i,
  input  logic [7:0]            out_byte_i,
  input  logic [LengthBits-1:0] length_i,
  input  logic                  status_i,
  input  logic                  run_end_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [LengthBits-1:0] out_capacity_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam logic [7:0] ChNul = 8'h00;

  typedef struct packed {
    logic                  kind;
    logic [7:0]            data;
    logic [LengthBits-1:0] len;
    logic                  st;
    logic                  run_end;
  } result_t;

  // Own copy of the capacity register and of the decoder state.
  logic [LengthBits-1:0] capacity;
  mode_e                 mode;
  logic [1:0]            digit_count;
  logic [7:0]            octal_value;
  logic [LengthBits-1:0] out_count;
  logic                  stopped_early;
  logic                  halted;

  // Decoded results still owed by the block, oldest first.
  result_t     decoded_q[$];
  result_t     char_results[$];
  result_t     want;
  result_t     got;
  int unsigned fail_count = 0;
  int unsigned pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o = pending;

  function automatic logic is_octal(input logic [7:0] c);
    return c >= ChZero && c <= ChSeven;
  endfunction

  task automatic clear_state();
    mode = ModeNormal;
    digit_count = '0;
    octal_value = '0;
    out_count = '0;
    stopped_early = 1'b0;
    halted = 1'b0;
  endtask

  // A byte counts (saturating) but leaves the block only below the terminator slot.
  task automatic emit_data(input logic [7:0] b);
    result_t r;
    r = '0;
    r.data = b;
    if (int'(out_count) + 1 < int'(capacity)) char_results.push_back(r);
    if (out_count != CountMax) out_count = out_count + 1'b1;
  endtask

  // A character outside an escape: stop on NUL or a full output, else decode.
  task automatic take_normal(input logic [7:0] c);
    if (out_count == capacity || c == ChNul) begin
      halted = 1'b1;
      stopped_early = 1'b1;
    end else if (c == ChBackslash) begin
      mode = ModeEscape;
    end else begin
      emit_data(c);
    end
  endtask

  // Works out the results of one accepted character and queues them.
  task automatic decode_char(input logic [7:0] c, input logic ends);
    result_t               r;
    logic [LengthBits-1:0] len;
    char_results.delete();
    if (!halted) begin
      case (mode)
        ModeNormal: begin
          take_normal(c);
        end
        ModeEscape: begin
          if (c == ChBackslash) begin
            mode = ModeNormal;
            emit_data(ChBackslash);
          end else if (is_octal(c)) begin
            octal_value = {5'd0, c[2:0]};
            digit_count = 2'd1;
            mode = ModeDigits;
            if (ends) begin
              mode = ModeNormal;
              emit_data(octal_value);
            end
          end else begin
            mode = ModeNormal;
            emit_data(ChNul);
            take_normal(c);
          end
        end
        default: begin
          if (is_octal(c) && digit_count < MaxDigits) begin
            octal_value = {octal_value[4:0], c[2:0]};
            digit_count = digit_count + 2'd1;
            if (digit_count >= MaxDigits || ends) begin
              mode = ModeNormal;
              emit_data(octal_value);
            end
          end else begin
            mode = ModeNormal;
            emit_data(octal_value);
            take_normal(c);
          end
        end
      endcase
    end
    // The final character closes the string with a summary item.
    if (ends) begin
      len = out_count;
      if (len != '0 && len == capacity) len = len - 1'b1;
      r = '0;
      r.kind = 1'b1;
      r.len = len;
      r.st = stopped_early;
      char_results.push_back(r);
      clear_state();
    end
    foreach (char_results[i]) begin
      r = char_results[i];
      r.run_end = (i == char_results.size() - 1);
      decoded_q.push_back(r);
    end
  endtask

  // Watch the three channels at every edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity = CapacityReset;
      clear_state();
      decoded_q.delete();
    end else begin
      if (pop_i && !empty_i) begin
        got = {kind_i, out_byte_i, length_i, status_i, run_end_i};
        if (decoded_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result: kind %0d byte %02h length %0d status %0d end %0d",
                     got.kind, got.data, got.len, got.st, got.run_end);
          end
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: expected kind %0d byte %02h length %0d status %0d end %0d",
                       want.kind, want.data, want.len, want.st, want.run_end);
              $display("          got      kind %0d byte %02h length %0d status %0d end %0d",
                       got.kind, got.data, got.len, got.st, got.run_end);
            end
            fail_count++;
          end
        end
      end
      if (push_i && !full_i) decode_char(in_char_i, last_char_i);
      if (cfg_valid_i && cfg_ready_i) capacity = out_capacity_i;
    end
    pending = decoded_q.size();
  end

endmodule

[tb/octal_escape_decoder_top_tb.sv]
// Testbench top of the octal escape decoder: stimulus, idling and verdict.
`timescale 1ns / 1ps
module octal_escape_decoder_top_tb;
  import oed_pkg::*;

  localparam logic [7:0] ChNul = 8'h00;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems = 20;
  localparam int unsigned NumPhases = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic [7:0]            in_char;
  logic                  last_char;
  logic                  empty;
  logic                  pop;
  logic                  res_kind;
  logic [7:0]            res_byte;
  logic [LengthBits-1:0] res_len;
  logic                  res_status;
  logic                  res_run_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [LengthBits-1:0] cfg_capacity;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent_items = 0;
  int unsigned idle_cycles;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  octal_escape_decoder_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .in_char_i     (in_char),
    .last_char_i   (last_char),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (res_kind),
    .out_byte_o    (res_byte),
    .length_o      (res_len),
    .status_o      (res_status),
    .run_end_o     (res_run_end),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .out_capacity_i(cfg_capacity)
  );

  octal_escape_decoder_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push_i        (push),
    .full_i        (full),
    .in_char_i     (in_char),
    .last_char_i   (last_char),
    .empty_i       (empty),
    .pop_i         (pop),
    .kind_i        (res_kind),
    .out_byte_i    (res_byte),
    .length_i      (res_len),
    .status_i      (res_status),
    .run_end_i     (res_run_end),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .out_capacity_i(cfg_capacity),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly escapes and octal digits, so that most strings are well formed.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return ChBackslash;
      3, 4, 5: return ChZero + 8'($urandom_range(0, 7));
      6:       return 8'($urandom_range(0, 255));
      7:       return ($urandom_range(0, 3) == 0) ? ChNul : 8'($urandom_range(8'h38, 8'h39));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  // Offers one item, after a random gap when idling is on.
  task automatic send_char(input logic [7:0] c, input logic ends);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    push <= 1'b1;
    in_char <= c;
    last_char <= ends;
    do @(posedge clk); while (full);
    sent_items++;
  endtask

  task automatic send_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) send_char(s[i], ends && i == s.len() - 1);
  endtask

  // Waits until every expected result has come and the pipeline has settled.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [LengthBits-1:0] cap);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    pop <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [LengthBits-1:0] cap;
    int unsigned           phase_start;
    int unsigned           str_len;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_char <= '0;
    last_char <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_capacity <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every escape form at the reset capacity, with wrap-round and the top byte.
    send_text("A\\\\\\101\\7x\\q\\777", 1'b0);
    send_char(8'hFF, 1'b0);
    // Digits still pending on the final character.
    send_text("\\12", 1'b1);
    // A lone backslash as the final character.
    send_text("\\", 1'b1);
    // NUL stops decoding; the rest is ignored until the final character.
    send_text("b", 1'b0);
    send_char(ChNul, 1'b0);
    send_text("cd", 1'b1);
    // Terminator slot and a full output, then full on the final character.
    write_capacity(LengthBits'(2));
    send_text("abc", 1'b1);
    send_text("ab", 1'b1);
    // No room at all.
    write_capacity('0);
    send_text("a", 1'b1);

    // Random strings under several capacities, the extremes among them.
    for (int k = 0; k < NumPhases; k++) begin
      case (k)
        0:       cap = LengthBits'(1);
        1:       cap = LengthBits'(6);
        2:       cap = CountMax;
        3:       cap = LengthBits'(9);
        4:       cap = '0;
        5:       cap = CapacityReset;
        6:       cap = LengthBits'(4);
        default: cap = LengthBits'(40);
      endcase
      write_capacity(cap);
      // The widest setting carries the long receiver hold-off; the last phase runs flat out.
      idle_on = (k != 2 && k != NumPhases - 1);
      hold_req = (k == 2);
      phase_start = sent_items;
      while (sent_items - phase_start < PhaseItems) begin
        str_len = $urandom_range(1, 10);
        for (int i = 0; i < str_len; i++) send_char(pick_char(), i == str_len - 1);
      end
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
